@@ hdl/stm_pkg.sv @@
// Shared types, constants and helper functions for the subscription tag matcher.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package stm_pkg;

   localparam int CAPACITY  = 32;
   localparam int ID_W      = 16;
   localparam int TAG_W     = 64;
   localparam int FLAG_W    = 8;
   localparam int LIM_W     = 6;
   localparam int OUT_MAX   = 32;
   localparam int TALLY_MAX = 63;

   // Actions of an input item.
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_FIND   = 2'd2;
   localparam logic [1:0] ACT_PURGE  = 2'd3;

   // Result status codes.
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_PRESENT  = 2'd1;
   localparam logic [1:0] STS_FULL     = 2'd2;
   localparam logic [1:0] STS_NOTFOUND = 2'd3;

   // Compare modes of a cell.
   localparam logic [1:0] MODE_EXACT  = 2'd0;
   localparam logic [1:0] MODE_ID     = 2'd1;
   localparam logic [1:0] MODE_SUBSET = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [TAG_W-1:0]  tags;
      logic [FLAG_W-1:0] flags;
   } entry_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [TAG_W-1:0] tags;
   } key_type;

   typedef struct packed {
      logic       shift_up;
      logic       shift_down;
      logic [1:0] mode;
   } cell_ctrl_type;

   // Inclusive prefix OR from bit 0 upward, built as a log-depth network.
   function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
      logic [CAPACITY-1:0] r;
      r = v;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         r = r | (r << s);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/subscription_tag_matcher_core.sv @@
// Subscription tag matcher: a chain of CAPACITY cells, newest entry in cell 0.
// Add, remove and purge: compare, then decide, which registers the result and frees
// the input for the next item; purge compares and shifts again for each removed entry.
// Find: n results (up to 32, at least one) after decide; the next item is taken after the last.
// Reset (synchronous, active high) empties the table at once and drops any pending result.
// Depends on stm_pkg and stm_cell.
`default_nettype none

module subscription_tag_matcher_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [1:0]                  req_action,
   input  wire logic [stm_pkg::ID_W-1:0]    req_proc_id,
   input  wire logic [stm_pkg::TAG_W-1:0]   req_tag_mask,
   input  wire logic [stm_pkg::FLAG_W-1:0]  req_entry_flags_in,
   input  wire logic [stm_pkg::LIM_W-1:0]   req_max_matches,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [1:0]                  rsp_status,
   output      logic                        rsp_has_id,
   output      logic [stm_pkg::ID_W-1:0]    rsp_match_id,
   output      logic [stm_pkg::LIM_W-1:0]   rsp_tally,
   output      logic                        rsp_last
);
   import stm_pkg::*;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CMP    = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_FIND   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [1:0]          mode_ff, mode_in;
   logic [ID_W-1:0]     key_id_ff, key_id_in;
   logic [TAG_W-1:0]    key_tags_ff, key_tags_in;
   logic [FLAG_W-1:0]   flags_ff, flags_in;
   logic [LIM_W-1:0]    lim_ff, lim_in;
   logic [LIM_W-1:0]    found_ff, found_in;
   logic [LIM_W-1:0]    removed_ff, removed_in;
   logic [CAPACITY-1:0] pend_ff, pend_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_has_id_ff, rsp_has_id_in;
   logic [ID_W-1:0]     rsp_match_id_ff, rsp_match_id_in;
   logic [LIM_W-1:0]    rsp_tally_ff, rsp_tally_in;
   logic                rsp_last_ff, rsp_last_in;

   entry_type           cell_q [CAPACITY];
   cell_ctrl_type       cell_ctrl [CAPACITY];
   logic [CAPACITY-1:0] hit_vec;
   logic [CAPACITY-1:0] vld_vec;
   logic [CAPACITY-1:0] del_sel;
   logic [CAPACITY-1:0] pick;
   logic [CAPACITY-1:0] pend_rest;
   logic [ID_W-1:0]     pick_id;
   entry_type           new_entry;
   entry_type           empty_entry;
   key_type             key;
   logic                do_up, do_down;
   logic                any_hit, full, slot_free;
   logic                find_empty, find_last;

   assign key.id            = key_id_ff;
   assign key.tags          = key_tags_ff;
   assign new_entry.valid   = 1'b1;
   assign new_entry.id      = key_id_ff;
   assign new_entry.tags    = key_tags_ff;
   assign new_entry.flags   = flags_ff;
   assign empty_entry       = '0;

   // The chain: each cell sees its newer neighbor for an insert and its older
   // neighbor for a delete. Cell 0 takes the new entry; the oldest cell takes
   // an empty slot when the table closes a gap.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type prev_e, next_e;
      if (i == 0) begin : g_head
         assign prev_e = new_entry;
      end else begin : g_mid_prev
         assign prev_e = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_e = empty_entry;
      end else begin : g_mid_next
         assign next_e = cell_q[i+1];
      end

      assign cell_ctrl[i].shift_up   = do_up;
      assign cell_ctrl[i].shift_down = do_down & del_sel[i];
      assign cell_ctrl[i].mode       = mode_ff;

      stm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[i]),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .key        (key),
         .entry      (cell_q[i]),
         .hit        (hit_vec[i])
      );
      assign vld_vec[i] = cell_q[i].valid;
   end

   // Entries stay packed from cell 0, so the oldest cell being valid means full.
   assign any_hit   = |hit_vec;
   assign full      = cell_q[CAPACITY-1].valid;
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // Deleting the newest hit: that cell and every older one pull from the next cell.
   assign del_sel = prefix_or(hit_vec);

   // Find walks the registered hit vector from newest to oldest, one id per cycle while the output slot is free.
   assign pick      = pend_ff & (~pend_ff + CAPACITY'(1));
   assign pend_rest = pend_ff & ~pick;

   always_comb begin
      pick_id = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         pick_id = pick_id | ({ID_W{pick[i]}} & cell_q[i].id);
      end
   end

   assign find_empty = (pend_ff == '0) || (lim_ff == '0);
   assign find_last  = (pend_rest == '0) || ((found_ff + LIM_W'(1)) == lim_ff);

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      mode_in         = mode_ff;
      key_id_in       = key_id_ff;
      key_tags_in     = key_tags_ff;
      flags_in        = flags_ff;
      lim_in          = lim_ff;
      found_in        = found_ff;
      removed_in      = removed_ff;
      pend_in         = pend_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_has_id_in   = rsp_has_id_ff;
      rsp_match_id_in = rsp_match_id_ff;
      rsp_tally_in    = rsp_tally_ff;
      rsp_last_in     = rsp_last_ff;
      do_up           = 1'b0;
      do_down         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_action;
               key_id_in   = req_proc_id;
               key_tags_in = req_tag_mask;
               flags_in    = req_entry_flags_in;
               lim_in      = (req_max_matches > LIM_W'(OUT_MAX)) ? LIM_W'(OUT_MAX)
                                                                : req_max_matches;
               removed_in  = '0;
               case (req_action)
                  ACT_ADD:    mode_in = MODE_EXACT;
                  ACT_REMOVE: mode_in = MODE_EXACT;
                  ACT_FIND:   mode_in = MODE_SUBSET;
                  ACT_PURGE:  mode_in = MODE_ID;
                  default:    mode_in = MODE_EXACT;
               endcase
               state_in = ST_CMP;
            end
         end

         // The cells register their compare results during this cycle.
         ST_CMP: begin
            state_in = ST_DECIDE;
         end

         ST_DECIDE: begin
            if (slot_free) begin
               rsp_status_in   = STS_OK;
               rsp_has_id_in   = 1'b0;
               rsp_match_id_in = '0;
               rsp_tally_in    = '0;
               rsp_last_in     = 1'b1;
               state_in        = ST_IDLE;
               case (op_ff)
                  ACT_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (any_hit) begin
                        rsp_status_in = STS_PRESENT;
                     end else if (full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        do_up = 1'b1;
                     end
                  end
                  ACT_REMOVE: begin
                     rsp_valid_in = 1'b1;
                     if (any_hit) begin
                        do_down = 1'b1;
                     end else begin
                        rsp_status_in = STS_NOTFOUND;
                     end
                  end
                  ACT_PURGE: begin
                     if (any_hit) begin
                        // Remove the newest match and compare again.
                        do_down    = 1'b1;
                        removed_in = (removed_ff == LIM_W'(TALLY_MAX)) ? removed_ff
                                                                       : removed_ff + LIM_W'(1);
                        state_in   = ST_CMP;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_tally_in = removed_ff;
                     end
                  end
                  ACT_FIND: begin
                     pend_in  = hit_vec;
                     found_in = '0;
                     state_in = ST_FIND;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_FIND: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
               if (find_empty) begin
                  rsp_has_id_in   = 1'b0;
                  rsp_match_id_in = '0;
                  rsp_tally_in    = '0;
                  rsp_last_in     = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  rsp_has_id_in   = 1'b1;
                  rsp_match_id_in = pick_id;
                  rsp_tally_in    = found_ff + LIM_W'(1);
                  rsp_last_in     = find_last;
                  pend_in         = pend_rest;
                  found_in        = found_ff + LIM_W'(1);
                  if (find_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         op_ff        <= ACT_ADD;
         mode_ff      <= MODE_EXACT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      key_id_ff       <= key_id_in;
      key_tags_ff     <= key_tags_in;
      flags_ff        <= flags_in;
      lim_ff          <= lim_in;
      found_ff        <= found_in;
      removed_ff      <= removed_in;
      pend_ff         <= pend_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_has_id_ff   <= rsp_has_id_in;
      rsp_match_id_ff <= rsp_match_id_in;
      rsp_tally_ff    <= rsp_tally_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_has_id   = rsp_has_id_ff;
   assign rsp_match_id = rsp_match_id_ff;
   assign rsp_tally    = rsp_tally_ff;
   assign rsp_last     = rsp_last_ff;

   // The table stays packed: no valid cell sits behind an empty one.
   a_packed: assert property (@(posedge clock) disable iff (reset)
      ((vld_vec >> 1) & ~vld_vec) == '0)
      else $error("subscription table has a gap");

   // A successful add grows the table by exactly one entry.
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && op_ff == ACT_ADD && slot_free && !any_hit && !full)
      |=> ($countones(vld_vec) == $past($countones(vld_vec)) + 1))
      else $error("add did not insert one entry");

   // While listing matches, the count given so far stays below the limit.
   a_find_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND) |-> (found_ff < lim_ff || lim_ff == '0))
      else $error("find went past its limit");

endmodule

`default_nettype wire

@@ hdl/stm_cell.sv @@
// One table slot of the subscription chain: holds an entry and its compare result.
// Depends on stm_pkg.
`default_nettype none

module stm_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire stm_pkg::cell_ctrl_type ctrl,
   input  wire stm_pkg::entry_type    prev_entry,
   input  wire stm_pkg::entry_type    next_entry,
   input  wire stm_pkg::key_type      key,
   output      stm_pkg::entry_type    entry,
   output      logic                  hit
);
   import stm_pkg::*;

   logic              valid_ff, valid_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TAG_W-1:0]  tags_ff, tags_in;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   logic              hit_ff, hit_in;
   logic              id_eq, tags_eq, subset;

   // Shift up takes the newer neighbor, shift down the older one.
   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      tags_in  = tags_ff;
      flags_in = flags_ff;
      if (ctrl.shift_up) begin
         valid_in = prev_entry.valid;
         id_in    = prev_entry.id;
         tags_in  = prev_entry.tags;
         flags_in = prev_entry.flags;
      end else if (ctrl.shift_down) begin
         valid_in = next_entry.valid;
         id_in    = next_entry.id;
         tags_in  = next_entry.tags;
         flags_in = next_entry.flags;
      end
   end

   assign id_eq   = (id_ff == key.id);
   assign tags_eq = (tags_ff == key.tags);
   assign subset  = ((tags_ff & key.tags) == tags_ff);

   always_comb begin
      case (ctrl.mode)
         MODE_EXACT:  hit_in = valid_ff & id_eq & tags_eq;
         MODE_ID:     hit_in = valid_ff & id_eq;
         MODE_SUBSET: hit_in = valid_ff & subset;
         default:     hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      tags_ff  <= tags_in;
      flags_ff <= flags_in;
   end

   assign entry.valid = valid_ff;
   assign entry.id    = id_ff;
   assign entry.tags  = tags_ff;
   assign entry.flags = flags_ff;
   assign hit         = hit_ff;

endmodule

`default_nettype wire

@@ tb/subscription_tag_matcher_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for subscription_tag_matcher_core: directed and random items
// go through the req_/rsp_ handshakes, and a scoreboard class predicts every result.
// Depends on stm_pkg and the subscription_tag_matcher_core RTL.

module subscription_tag_matcher_core_tb;
   import stm_pkg::*;

   // One input item as it is driven on the req_ ports.
   typedef struct packed {
      logic [1:0]        action;
      logic [ID_W-1:0]   id;
      logic [TAG_W-1:0]  tags;
      logic [FLAG_W-1:0] flags;
      logic [LIM_W-1:0]  limit;
   } request_type;

   // One result item as it appears on the rsp_ ports.
   typedef struct packed {
      logic [1:0]       status;
      logic             has_id;
      logic [ID_W-1:0]  match_id;
      logic [LIM_W-1:0] tally;
      logic             last;
   } reply_type;

   localparam logic [TAG_W-1:0] TAGS_ALL  = {TAG_W{1'b1}};
   localparam logic [TAG_W-1:0] TAGS_NONE = '0;
   localparam int RANDOM_ITEMS = 280;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 20;

   // The scoreboard keeps its own copy of the subscription list, packed newest first,
   // and a queue of the results that the accepted items must still produce.
   class sub_list_scoreboard;
      logic [ID_W-1:0]   entry_id[CAPACITY];
      logic [TAG_W-1:0]  entry_tags[CAPACITY];
      logic [FLAG_W-1:0] entry_flags[CAPACITY];
      int                entry_count;
      reply_type         expected_q[$];
      int                errors;

      function new();
         entry_count = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string what);
         if (errors < 40) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
         end
         errors++;
      endtask

      function void push_reply(logic [1:0] status, logic has_id, logic [ID_W-1:0] id,
                                logic [LIM_W-1:0] tally, logic last);
         reply_type r;
         r.status = status;
         r.has_id = has_id;
         r.match_id = id;
         r.tally = tally;
         r.last = last;
         expected_q.push_back(r);
      endfunction

      function int exact_slot(logic [ID_W-1:0] id, logic [TAG_W-1:0] tags);
         for (int i = 0; i < entry_count; i++) begin
            if (entry_id[i] == id && entry_tags[i] == tags) return i;
         end
         return -1;
      endfunction

      // Closes the gap left by a removed entry so the list stays packed.
      function void drop_slot(int pos);
         for (int i = pos; i + 1 < entry_count; i++) begin
            entry_id[i] = entry_id[i+1];
            entry_tags[i] = entry_tags[i+1];
            entry_flags[i] = entry_flags[i+1];
         end
         entry_count--;
      endfunction

      // Applies one accepted item to the list and queues the results it must cause.
      function void note_request(request_type r);
         int pos;
         int found;
         int lim;
         int removed;
         case (r.action)
            ACT_ADD: begin
               // A duplicate is reported even when the list is also full.
               if (exact_slot(r.id, r.tags) >= 0) begin
                  push_reply(STS_PRESENT, 1'b0, '0, '0, 1'b1);
               end else if (entry_count >= CAPACITY) begin
                  push_reply(STS_FULL, 1'b0, '0, '0, 1'b1);
               end else begin
                  for (int i = entry_count; i > 0; i--) begin
                     entry_id[i] = entry_id[i-1];
                     entry_tags[i] = entry_tags[i-1];
                     entry_flags[i] = entry_flags[i-1];
                  end
                  entry_id[0] = r.id;
                  entry_tags[0] = r.tags;
                  entry_flags[0] = r.flags;
                  entry_count++;
                  push_reply(STS_OK, 1'b0, '0, '0, 1'b1);
               end
            end
            ACT_REMOVE: begin
               pos = exact_slot(r.id, r.tags);
               if (pos >= 0) begin
                  drop_slot(pos);
                  push_reply(STS_OK, 1'b0, '0, '0, 1'b1);
               end else begin
                  push_reply(STS_NOTFOUND, 1'b0, '0, '0, 1'b1);
               end
            end
            ACT_FIND: begin
               // An entry matches when its required tags are a subset of the event tags.
               lim = (r.limit > OUT_MAX) ? OUT_MAX : int'(r.limit);
               found = 0;
               for (int i = 0; i < entry_count && found < lim; i++) begin
                  if ((entry_tags[i] & r.tags) == entry_tags[i]) begin
                     found++;
                     push_reply(STS_OK, 1'b1, entry_id[i], LIM_W'(found), 1'b0);
                  end
               end
               if (found == 0) begin
                  push_reply(STS_OK, 1'b0, '0, '0, 1'b1);
               end else begin
                  expected_q[expected_q.size()-1].last = 1'b1;
               end
            end
            default: begin
               removed = 0;
               pos = 0;
               while (pos < entry_count) begin
                  if (entry_id[pos] == r.id) begin
                     drop_slot(pos);
                     removed++;
                  end else begin
                     pos++;
                  end
               end
               if (removed > TALLY_MAX) removed = TALLY_MAX;
               push_reply(STS_OK, 1'b0, '0, LIM_W'(removed), 1'b1);
            end
         endcase
      endfunction

      task check_reply(reply_type got);
         reply_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing expected: status %0d id %h tally %0d",
                             got.status, got.match_id, got.tally));
         end else begin
            want = expected_q.pop_front();
            if (got.status !== want.status)
               report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.has_id !== want.has_id)
               report($sformatf("has_id %b, wanted %b", got.has_id, want.has_id));
            if (got.match_id !== want.match_id)
               report($sformatf("match_id %h, wanted %h", got.match_id, want.match_id));
            if (got.tally !== want.tally)
               report($sformatf("tally %0d, wanted %0d", got.tally, want.tally));
            if (got.last !== want.last)
               report($sformatf("last %b, wanted %b", got.last, want.last));
         end
      endtask

      task close_out();
         if (expected_q.size() != 0)
            report($sformatf("%0d expected results never arrived", expected_q.size()));
      endtask
   endclass

   // Every input of the block starts at a known value.
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_action = ACT_ADD;
   logic [ID_W-1:0]   req_proc_id = '0;
   logic [TAG_W-1:0]  req_tag_mask = '0;
   logic [FLAG_W-1:0] req_entry_flags_in = '0;
   logic [LIM_W-1:0]  req_max_matches = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic              rsp_has_id;
   logic [ID_W-1:0]   rsp_match_id;
   logic [LIM_W-1:0]  rsp_tally;
   logic              rsp_last;

   sub_list_scoreboard sb;
   bit                 hold_request = 1'b0;
   int                 burst_left = 0;
   logic [ID_W-1:0]    id_pool[4];

   subscription_tag_matcher_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_proc_id        (req_proc_id),
      .req_tag_mask       (req_tag_mask),
      .req_entry_flags_in (req_entry_flags_in),
      .req_max_matches    (req_max_matches),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_has_id         (rsp_has_id),
      .rsp_match_id       (rsp_match_id),
      .rsp_tally          (rsp_tally),
      .rsp_last           (rsp_last)
   );

   always #1 clock = ~clock;

   // Results are sampled at the rising edge, so the values seen are the ones that were
   // stable before the edge; the block and the receiver both update after it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_reply({rsp_status, rsp_has_id, rsp_match_id, rsp_tally, rsp_last});
      end
   end

   // The receiver stalls on a pattern of its own. Once during the run it holds off for a
   // long stretch so that the block backs up and stops taking items.
   initial begin
      int n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            case ($urandom_range(0, 9))
               0: begin
                  // A long stretch with no stall at all.
                  n = $urandom_range(40, 80);
                  rsp_ready <= 1'b1;
               end
               1, 2: begin
                  n = $urandom_range(1, 4);
                  rsp_ready <= 1'b0;
               end
               3: begin
                  n = $urandom_range(5, 12);
                  rsp_ready <= 1'b0;
               end
               default: begin
                  n = $urandom_range(1, 6);
                  rsp_ready <= 1'b1;
               end
            endcase
            repeat (n) @(posedge clock);
         end
      end
   end

   // Drives one item and returns at the edge where it is accepted. It is always called at
   // a rising edge, and valid stays high into the next item when no gap follows.
   task automatic send_request(input request_type r);
      req_valid <= 1'b1;
      req_action <= r.action;
      req_proc_id <= r.id;
      req_tag_mask <= r.tags;
      req_entry_flags_in <= r.flags;
      req_max_matches <= r.limit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   // The sender works in bursts; between bursts it may leave valid low for a random gap.
   task automatic pace_sender();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops offering items until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic request_type make_request(logic [1:0] action, logic [ID_W-1:0] id,
                                                logic [TAG_W-1:0] tags,
                                                logic [FLAG_W-1:0] flags,
                                                logic [LIM_W-1:0] limit);
      request_type r;
      r.action = action;
      r.id = id;
      r.tags = tags;
      r.flags = flags;
      r.limit = limit;
      return r;
   endfunction

   // Ids mostly come from a small pool so that duplicates, exact removes and purges of
   // several entries happen often.
   function automatic logic [ID_W-1:0] pick_id();
      case ($urandom_range(0, 9))
         0:             return '0;
         1:             return {ID_W{1'b1}};
         2, 3, 4, 5, 6: return id_pool[$urandom_range(0, 3)];
         default:       return ID_W'($urandom);
      endcase
   endfunction

   // Required masks are sparse and event tags dense, so that finds match a fair share.
   function automatic logic [TAG_W-1:0] sparse_tags();
      case ($urandom_range(0, 9))
         0:       return TAGS_NONE;
         1:       return TAGS_ALL;
         2:       return {$urandom, $urandom};
         default: return {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
      endcase
   endfunction

   function automatic logic [TAG_W-1:0] dense_tags();
      case ($urandom_range(0, 9))
         0:       return TAGS_ALL;
         1:       return TAGS_NONE;
         2:       return {$urandom, $urandom};
         default: return {$urandom | $urandom | $urandom, $urandom | $urandom | $urandom};
      endcase
   endfunction

   // Phase 0 fills the list up to and past full, phase 1 is an even mix and phase 2
   // leans on remove and purge to empty the list again.
   function automatic request_type gen_request(int phase);
      request_type r;
      int pct;
      int add_t;
      int rem_t;
      int find_t;
      int i;
      case (phase)
         0:       begin add_t = 95; rem_t = 97; find_t = 100; end
         1:       begin add_t = 35; rem_t = 60; find_t = 88;  end
         default: begin add_t = 15; rem_t = 55; find_t = 75;  end
      endcase
      r.id = pick_id();
      r.tags = sparse_tags();
      r.flags = FLAG_W'($urandom);
      r.limit = LIM_W'($urandom);
      pct = $urandom_range(0, 99);
      if (pct < add_t) begin
         r.action = ACT_ADD;
         if (sb.entry_count > 0 && $urandom_range(0, 19) == 0) begin
            i = $urandom_range(0, sb.entry_count - 1);
            r.id = sb.entry_id[i];
            r.tags = sb.entry_tags[i];
         end
      end else if (pct < rem_t) begin
         r.action = ACT_REMOVE;
         if (sb.entry_count > 0 && $urandom_range(0, 3) != 0) begin
            i = $urandom_range(0, sb.entry_count - 1);
            r.id = sb.entry_id[i];
            r.tags = sb.entry_tags[i];
            // Now and then a near miss: right id, one tag bit off.
            if ($urandom_range(0, 7) == 0) r.tags = r.tags ^ (64'd1 << $urandom_range(0, 63));
         end
      end else if (pct < find_t) begin
         r.action = ACT_FIND;
         r.tags = dense_tags();
         case ($urandom_range(0, 19))
            0, 1, 2:    r.limit = '0;
            3, 4, 5, 6: r.limit = LIM_W'($urandom_range(OUT_MAX, 63));
            7, 8, 9:    r.limit = LIM_W'($urandom);
            default:    r.limit = LIM_W'($urandom_range(1, 8));
         endcase
      end else begin
         r.action = ACT_PURGE;
         if (sb.entry_count > 0 && $urandom_range(0, 9) < 7)
            r.id = sb.entry_id[$urandom_range(0, sb.entry_count - 1)];
      end
      return r;
   endfunction

   // Hard limit on the run; a correct run ends far earlier.
   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      request_type directed_q[$];
      sb = new();
      for (int k = 0; k < 4; k++) id_pool[k] = ID_W'($urandom_range(1, 65534));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: extremes of every field, every action and each corner case.
      // Find on an empty list gives a single no-match result.
      directed_q.push_back(make_request(ACT_FIND, 16'h0000, TAGS_ALL, 8'h00, 6'd63));
      directed_q.push_back(make_request(ACT_ADD, 16'h0000, TAGS_NONE, 8'h00, 6'd0));
      directed_q.push_back(make_request(ACT_ADD, 16'hFFFF, TAGS_ALL, 8'hFF, 6'd63));
      // The same id and mask again is rejected as already present.
      directed_q.push_back(make_request(ACT_ADD, 16'hFFFF, TAGS_ALL, 8'h00, 6'd0));
      directed_q.push_back(make_request(ACT_ADD, 16'h1234, 64'h0000_00F0_0000_8001,
                                        8'h5A, 6'd0));
      // A zero limit behaves like no match at all.
      directed_q.push_back(make_request(ACT_FIND, 16'hFFFF, TAGS_ALL, 8'hFF, 6'd0));
      // A limit above the result bound is capped; every entry matches here.
      directed_q.push_back(make_request(ACT_FIND, 16'h0000, TAGS_ALL, 8'h00, 6'd63));
      directed_q.push_back(make_request(ACT_FIND, 16'h0000, TAGS_NONE, 8'h00, 6'd32));
      directed_q.push_back(make_request(ACT_FIND, 16'h0000, 64'h0000_00F0_0000_8001,
                                        8'h00, 6'd1));
      directed_q.push_back(make_request(ACT_FIND, 16'h0000, 64'h0000_00F0_0000_8001,
                                        8'h00, 6'd2));
      // Remove with the right id but the wrong mask finds nothing.
      directed_q.push_back(make_request(ACT_REMOVE, 16'h1234, 64'h0000_00F0_0000_8000,
                                        8'h00, 6'd0));
      directed_q.push_back(make_request(ACT_REMOVE, 16'h1234, 64'h0000_00F0_0000_8001,
                                        8'h00, 6'd0));
      // Purge of an id that is not in the list removes nothing.
      directed_q.push_back(make_request(ACT_PURGE, 16'hABCD, TAGS_ALL, 8'h00, 6'd0));
      directed_q.push_back(make_request(ACT_ADD, 16'hFFFF, 64'h1, 8'h81, 6'd0));
      directed_q.push_back(make_request(ACT_ADD, 16'hFFFF, 64'h8000_0000_0000_0000,
                                        8'h7E, 6'd0));
      directed_q.push_back(make_request(ACT_PURGE, 16'hFFFF, TAGS_NONE, 8'hFF, 6'd63));
      directed_q.push_back(make_request(ACT_FIND, 16'h0000, 64'h8000_0000_0000_0001,
                                        8'h00, 6'd32));
      directed_q.push_back(make_request(ACT_REMOVE, 16'h0000, TAGS_NONE, 8'h00, 6'd0));
      // The list is empty again, so this remove reports not found.
      directed_q.push_back(make_request(ACT_REMOVE, 16'h0000, TAGS_NONE, 8'h00, 6'd0));
      directed_q.push_back(make_request(ACT_PURGE, 16'h0000, TAGS_NONE, 8'h00, 6'd0));

      foreach (directed_q[k]) begin
         send_request(directed_q[k]);
         pace_sender();
      end
      wait_drained();

      // Random items. The first phase fills the list past full, later phases mix and
      // drain it. The long receiver hold-off starts while the list is well stocked, and
      // halfway through the sender waits for every result before it goes on.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 60) hold_request = 1'b1;
         if (n == 140) wait_drained();
         send_request(gen_request((n / 45) % 3));
         pace_sender();
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
